// File: design/nitt_pkg.sv
package nitt_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned CofWidth  = 64;
   localparam int unsigned SumWidth  = 97;
   localparam int unsigned MagWidth  = 96;
   localparam int unsigned QuoWidth  = 34;
   localparam int unsigned DivShift  = 17;
   localparam int unsigned ThrWidth  = 31;
   localparam int unsigned DivStages = QuoWidth;

   localparam logic [ThrWidth-1:0] ThrReset = ThrWidth'(1);

   localparam logic [WordWidth-1:0] PosLimit = 32'h7FFF_FFFF;
   localparam logic [WordWidth-1:0] NegLimit = 32'h8000_0000;

   // matrix element index = row*3 + col; cofactor j = prod[2j] - prod[2j+1]
   localparam int unsigned ProdLeft  [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
   localparam int unsigned ProdRight [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

   // word select: 0..2 row 0, 3..5 normal; first three products form the determinant
   localparam int unsigned DotWord [12] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 3, 4, 5};
   localparam int unsigned DotCof  [12] = '{0, 1, 2, 0, 1, 2, 3, 4, 5, 6, 7, 8};

   typedef logic signed [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type row0_col0;
      word_type row0_col1;
      word_type row0_col2;
      word_type row1_col0;
      word_type row1_col1;
      word_type row1_col2;
      word_type row2_col0;
      word_type row2_col1;
      word_type row2_col2;
      word_type normal_x;
      word_type normal_y;
      word_type normal_z;
   } req_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      logic     singular;
      logic     saturated;
   } rsp_type;

   typedef struct packed {
      logic [8:0][CofWidth-1:0]  cof;
      logic [2:0][WordWidth-1:0] row0;
      logic [2:0][WordWidth-1:0] normal;
   } cof_beat_type;

   typedef struct packed {
      logic [SumWidth-1:0]       det;
      logic [2:0][SumWidth-1:0]  num;
      logic [2:0][WordWidth-1:0] normal;
   } dot_beat_type;

   typedef struct packed {
      logic [MagWidth-1:0] rem;
      logic [QuoWidth-1:0] feed;
      logic [QuoWidth-1:0] quo;
      logic                neg;
      logic                ovf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [2:0]        lane;
      logic [MagWidth-1:0]       dmag;
      logic                      singular;
      logic [2:0][WordWidth-1:0] normal;
   } div_beat_type;

endpackage

// File: design/nitt_cofactor.sv
module nitt_cofactor (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ce,
   input  logic                   in_valid,
   input  nitt_pkg::req_type      in_data,
   output logic                   out_valid,
   output nitt_pkg::cof_beat_type out_data
);

   nitt_pkg::word_type m [9];

   logic signed [nitt_pkg::CofWidth-1:0] prod_in [18];
   logic signed [nitt_pkg::CofWidth-1:0] prod_ff [18];
   logic signed [nitt_pkg::CofWidth-1:0] cof_in  [9];
   logic signed [nitt_pkg::CofWidth-1:0] cof_ff  [9];

   logic [2:0][nitt_pkg::WordWidth-1:0] row0_in;
   logic [2:0][nitt_pkg::WordWidth-1:0] row0_ff;
   logic [2:0][nitt_pkg::WordWidth-1:0] row0_out_ff;
   logic [2:0][nitt_pkg::WordWidth-1:0] normal_in;
   logic [2:0][nitt_pkg::WordWidth-1:0] normal_ff;
   logic [2:0][nitt_pkg::WordWidth-1:0] normal_out_ff;

   logic valid1_ff;
   logic valid2_ff;

   assign m[0] = in_data.row0_col0;
   assign m[1] = in_data.row0_col1;
   assign m[2] = in_data.row0_col2;
   assign m[3] = in_data.row1_col0;
   assign m[4] = in_data.row1_col1;
   assign m[5] = in_data.row1_col2;
   assign m[6] = in_data.row2_col0;
   assign m[7] = in_data.row2_col1;
   assign m[8] = in_data.row2_col2;

   assign row0_in   = {in_data.row0_col2, in_data.row0_col1, in_data.row0_col0};
   assign normal_in = {in_data.normal_z, in_data.normal_y, in_data.normal_x};

   always_comb begin
      for (int k = 0; k < 18; k++) begin
         prod_in[k] = m[nitt_pkg::ProdLeft[k]] * m[nitt_pkg::ProdRight[k]];
      end
      for (int j = 0; j < 9; j++) begin
         cof_in[j] = prod_ff[2*j] - prod_ff[2*j+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (ce) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         prod_ff       <= prod_in;
         cof_ff        <= cof_in;
         row0_ff       <= row0_in;
         row0_out_ff   <= row0_ff;
         normal_ff     <= normal_in;
         normal_out_ff <= normal_ff;
      end
   end

   always_comb begin
      for (int j = 0; j < 9; j++) begin
         out_data.cof[j] = cof_ff[j];
      end
      out_data.row0   = row0_out_ff;
      out_data.normal = normal_out_ff;
   end

   assign out_valid = valid2_ff;

endmodule

// File: design/nitt_dot.sv
module nitt_dot (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ce,
   input  logic                   in_valid,
   input  nitt_pkg::cof_beat_type in_data,
   output logic                   out_valid,
   output nitt_pkg::dot_beat_type out_data
);

   logic [nitt_pkg::WordWidth-1:0] words [6];

   logic signed [nitt_pkg::CofWidth:0]   lo_in  [12];
   logic signed [nitt_pkg::CofWidth:0]   lo_ff  [12];
   logic signed [nitt_pkg::CofWidth-1:0] hi_in  [12];
   logic signed [nitt_pkg::CofWidth-1:0] hi_ff  [12];
   logic signed [nitt_pkg::SumWidth-1:0] prod_in [12];
   logic signed [nitt_pkg::SumWidth-1:0] prod_ff [12];

   logic signed [nitt_pkg::SumWidth-1:0] det_in;
   logic signed [nitt_pkg::SumWidth-1:0] det_ff;
   logic [2:0][nitt_pkg::SumWidth-1:0]   num_in;
   logic [2:0][nitt_pkg::SumWidth-1:0]   num_ff;

   logic [2:0][nitt_pkg::WordWidth-1:0] normal1_ff;
   logic [2:0][nitt_pkg::WordWidth-1:0] normal2_ff;
   logic [2:0][nitt_pkg::WordWidth-1:0] normal3_ff;

   logic valid1_ff;
   logic valid2_ff;
   logic valid3_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         words[k]   = in_data.row0[k];
         words[k+3] = in_data.normal[k];
      end
      for (int p = 0; p < 12; p++) begin
         lo_in[p] = $signed(words[nitt_pkg::DotWord[p]])
                  * $signed({1'b0, in_data.cof[nitt_pkg::DotCof[p]][31:0]});
         hi_in[p] = $signed(words[nitt_pkg::DotWord[p]])
                  * $signed(in_data.cof[nitt_pkg::DotCof[p]][63:32]);
      end
      for (int p = 0; p < 12; p++) begin
         prod_in[p] = (nitt_pkg::SumWidth'(hi_ff[p]) <<< nitt_pkg::WordWidth)
                    + nitt_pkg::SumWidth'(lo_ff[p]);
      end
      det_in    = prod_ff[0] + prod_ff[1] + prod_ff[2];
      num_in[0] = prod_ff[3] + prod_ff[4] + prod_ff[5];
      num_in[1] = prod_ff[6] + prod_ff[7] + prod_ff[8];
      num_in[2] = prod_ff[9] + prod_ff[10] + prod_ff[11];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (ce) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         prod_ff    <= prod_in;
         det_ff     <= det_in;
         num_ff     <= num_in;
         normal1_ff <= in_data.normal;
         normal2_ff <= normal1_ff;
         normal3_ff <= normal2_ff;
      end
   end

   assign out_valid       = valid3_ff;
   assign out_data.det    = det_ff;
   assign out_data.num    = num_ff;
   assign out_data.normal = normal3_ff;

endmodule

// File: design/nitt_prep.sv
module nitt_prep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           ce,
   input  logic [nitt_pkg::ThrWidth-1:0]  threshold,
   input  logic                           in_valid,
   input  nitt_pkg::dot_beat_type         in_data,
   output logic                           out_valid,
   output nitt_pkg::div_beat_type         out_data
);

   function automatic logic [nitt_pkg::MagWidth-1:0] mag_of(
      input logic [nitt_pkg::SumWidth-1:0] v
   );
      logic [nitt_pkg::SumWidth-1:0] t;
      t = v[nitt_pkg::SumWidth-1] ? (~v + 1'b1) : v;
      return t[nitt_pkg::MagWidth-1:0];
   endfunction

   logic [nitt_pkg::MagWidth-1:0]       dmag_ff;
   logic [2:0][nitt_pkg::MagWidth-1:0]  nmag_ff;
   logic [2:0]                          neg_ff;
   logic [2:0][nitt_pkg::WordWidth-1:0] normal_ff;
   logic                                valid1_ff;

   nitt_pkg::div_beat_type beat_in;
   nitt_pkg::div_beat_type beat_ff;
   logic                   valid2_ff;

   logic [nitt_pkg::MagWidth-1:0] thr_mag;
   logic [nitt_pkg::MagWidth-1:0] top_bits;

   always_comb begin
      thr_mag = nitt_pkg::MagWidth'({threshold, 32'd0});
      beat_in.dmag     = dmag_ff;
      beat_in.normal   = normal_ff;
      beat_in.singular = (dmag_ff == '0) || (dmag_ff < thr_mag);
      top_bits = '0;
      for (int i = 0; i < 3; i++) begin
         top_bits = nmag_ff[i] >> nitt_pkg::DivShift;
         beat_in.lane[i].rem  = top_bits;
         beat_in.lane[i].feed = {nmag_ff[i][nitt_pkg::DivShift-1:0],
                                 (nitt_pkg::QuoWidth - nitt_pkg::DivShift)'(0)};
         beat_in.lane[i].quo  = '0;
         beat_in.lane[i].neg  = neg_ff[i];
         beat_in.lane[i].ovf  = top_bits >= dmag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (ce) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dmag_ff   <= mag_of(in_data.det);
         normal_ff <= in_data.normal;
         for (int i = 0; i < 3; i++) begin
            nmag_ff[i] <= mag_of(in_data.num[i]);
            neg_ff[i]  <= in_data.num[i][nitt_pkg::SumWidth-1]
                        ^ in_data.det[nitt_pkg::SumWidth-1];
         end
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_data  = beat_ff;

endmodule

// File: design/nitt_div_step.sv
module nitt_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ce,
   input  logic                   in_valid,
   input  nitt_pkg::div_beat_type in_data,
   output logic                   out_valid,
   output nitt_pkg::div_beat_type out_data
);

   nitt_pkg::div_beat_type beat_in;
   nitt_pkg::div_beat_type beat_ff;
   logic                   valid_ff;

   // one quotient bit per lane: shift in next numerator bit, trial subtract
   always_comb begin
      logic [nitt_pkg::MagWidth:0]   trial;
      logic [nitt_pkg::MagWidth+1:0] diff;
      logic                          ge;
      beat_in = in_data;
      for (int i = 0; i < 3; i++) begin
         trial = {in_data.lane[i].rem, in_data.lane[i].feed[nitt_pkg::QuoWidth-1]};
         diff  = {1'b0, trial} - {2'b00, in_data.dmag};
         ge    = !diff[nitt_pkg::MagWidth+1];
         beat_in.lane[i].rem  = ge ? diff[nitt_pkg::MagWidth-1:0]
                                   : trial[nitt_pkg::MagWidth-1:0];
         beat_in.lane[i].feed = in_data.lane[i].feed << 1;
         beat_in.lane[i].quo  = {in_data.lane[i].quo[nitt_pkg::QuoWidth-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ce) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = beat_ff;

endmodule

// File: design/normal_inverse_transpose_transform.sv
// Pipeline stages from req beat to rsp beat: 2 cofactor, 3 dot product, 2 magnitude
// and range check, 34 restoring divide steps, 1 rounding and output register.
// Throughput: one beat per cycle; the whole pipe advances together and halts only
// while a result sits in the output register unread.
// Reset (synchronous, active high) empties the pipe and sets the threshold to 1.
module normal_inverse_transpose_transform (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  nitt_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output nitt_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nitt_pkg::ThrWidth-1:0] csr_data
);

   logic ce;

   logic [nitt_pkg::ThrWidth-1:0] threshold_ff;

   logic                   cof_valid;
   nitt_pkg::cof_beat_type cof_data;
   logic                   dot_valid;
   nitt_pkg::dot_beat_type dot_data;

   logic                   div_valid [nitt_pkg::DivStages+1];
   nitt_pkg::div_beat_type div_data  [nitt_pkg::DivStages+1];

   nitt_pkg::rsp_type rsp_in;
   nitt_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   assign ce        = !rsp_valid_ff || rsp_ready;
   assign req_ready = ce;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= nitt_pkg::ThrReset;
      end else if (csr_valid) begin
         threshold_ff <= csr_data;
      end
   end

   nitt_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (cof_valid),
      .out_data  (cof_data)
   );

   nitt_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (cof_valid),
      .in_data   (cof_data),
      .out_valid (dot_valid),
      .out_data  (dot_data)
   );

   nitt_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .threshold (threshold_ff),
      .in_valid  (dot_valid),
      .in_data   (dot_data),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0])
   );

   for (genvar s = 0; s < nitt_pkg::DivStages; s++) begin : g_div
      nitt_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .ce        (ce),
         .in_valid  (div_valid[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   // quotient carries one fraction bit: round half away from zero, then clip
   always_comb begin
      logic [nitt_pkg::QuoWidth:0]    sum;
      logic [nitt_pkg::QuoWidth-1:0]  rnd;
      logic [nitt_pkg::WordWidth-1:0] val [3];
      logic [2:0]                     sat;
      nitt_pkg::div_beat_type         beat;
      beat = div_data[nitt_pkg::DivStages];
      for (int i = 0; i < 3; i++) begin
         sum = {1'b0, beat.lane[i].quo} + 1'b1;
         rnd = sum[nitt_pkg::QuoWidth:1];
         if (beat.lane[i].neg) begin
            sat[i] = beat.lane[i].ovf
                   || (rnd > nitt_pkg::QuoWidth'(nitt_pkg::NegLimit));
            val[i] = sat[i] ? nitt_pkg::NegLimit : (~rnd[nitt_pkg::WordWidth-1:0] + 1'b1);
         end else begin
            sat[i] = beat.lane[i].ovf
                   || (rnd > nitt_pkg::QuoWidth'(nitt_pkg::PosLimit));
            val[i] = sat[i] ? nitt_pkg::PosLimit : rnd[nitt_pkg::WordWidth-1:0];
         end
      end
      if (beat.singular) begin
         rsp_in.out_x     = beat.normal[0];
         rsp_in.out_y     = beat.normal[1];
         rsp_in.out_z     = beat.normal[2];
         rsp_in.singular  = 1'b1;
         rsp_in.saturated = 1'b0;
      end else begin
         rsp_in.out_x     = val[0];
         rsp_in.out_y     = val[1];
         rsp_in.out_z     = val[2];
         rsp_in.singular  = 1'b0;
         rsp_in.saturated = |sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= div_valid[nitt_pkg::DivStages];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.singular && rsp_data.saturated))
      else $error("singular beat flagged as saturated");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.out_x == nitt_pkg::PosLimit || rsp_data.out_x == nitt_pkg::NegLimit
          || rsp_data.out_y == nitt_pkg::PosLimit || rsp_data.out_y == nitt_pkg::NegLimit
          || rsp_data.out_z == nitt_pkg::PosLimit || rsp_data.out_z == nitt_pkg::NegLimit))
      else $error("saturated beat without a clipped component");

   assert property (@(posedge clock)
      reset |=> (threshold_ff == nitt_pkg::ThrReset))
      else $error("threshold not restored by reset");
`endif

endmodule
